>>> hw/rtl/flip_segment_update_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Flip segment sequencer assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FLIP_SEGMENT_UPDATE_SEQUENCER_ASSERT_SVH
`define FLIP_SEGMENT_UPDATE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define FSU_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSU_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fsu_pkg.sv
// ----------------------------------------------------------------------------
// fsu_pkg
// Shared constants, types and the glyph table of the flip segment sequencer.
// ----------------------------------------------------------------------------
package fsu_pkg;

  localparam int DIGITS        = 4;
  localparam int SEGMENTS      = 7;
  localparam int DIGIT_W       = 3;
  localparam int DIGIT_AW      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int SYMBOL_W      = 5;
  localparam int SEG_W         = 3;
  localparam int PORT_W        = 8;
  localparam int CMP_W         = 16;
  localparam int ELAPSED_W     = 19;
  localparam int CFG_IDX_W     = 2;
  localparam int CHIP_SEL_BASE = 4;
  localparam int PULLUP_BIT    = 3;

  // reset contents of every digit: all segments shown
  localparam logic [SEGMENTS-1:0] PATTERN_RESET = '1;

  localparam logic [CMP_W-1:0] SET_CMP_RESET = 16'd250;
  localparam logic [CMP_W-1:0] CLR_CMP_RESET = 16'd125;
  localparam logic [CMP_W-1:0] HOLD_RESET    = 16'd400;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_CMP = 2'd0,
    CFG_CLR_CMP = 2'd1,
    CFG_HOLD    = 2'd2
  } cfg_idx_e;

  // pattern store write port
  typedef struct packed {
    logic                en;
    logic [DIGIT_AW-1:0] addr;
    logic [SEGMENTS-1:0] data;
  } pat_wr_t;

  // hold time accumulator control
  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

  // symbol to segments, bit 0 = a ... bit 6 = g; unknown codes are blank
  function automatic logic [SEGMENTS-1:0] glyph(input logic [SYMBOL_W-1:0] sym);
    logic [SEGMENTS-1:0] g;
    unique case (sym)
      5'd0:    g = 7'h3F;
      5'd1:    g = 7'h06;
      5'd2:    g = 7'h5B;
      5'd3:    g = 7'h4F;
      5'd4:    g = 7'h66;
      5'd5:    g = 7'h6D;
      5'd6:    g = 7'h7D;
      5'd7:    g = 7'h07;
      5'd8:    g = 7'h7F;
      5'd9:    g = 7'h6F;
      5'd10:   g = 7'h77;
      5'd11:   g = 7'h7C;
      5'd12:   g = 7'h39;
      5'd13:   g = 7'h5E;
      5'd14:   g = 7'h79;
      5'd15:   g = 7'h71;
      5'd17:   g = 7'h40;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

endpackage

>>> hw/rtl/fsu_pattern_store.sv
// ----------------------------------------------------------------------------
// fsu_pattern_store
// Holds the segment pattern currently shown on each digit.
// ----------------------------------------------------------------------------
module fsu_pattern_store (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [fsu_pkg::DIGIT_AW-1:0]           rd_addr_i,
  output logic [fsu_pkg::SEGMENTS-1:0]           rd_data_o,
  input  fsu_pkg::pat_wr_t                       wr_i
);

  logic [fsu_pkg::SEGMENTS-1:0] pat_q [fsu_pkg::DIGITS];

  // one register per digit, all segments shown after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fsu_pkg::DIGITS; i++) begin
        pat_q[i] <= fsu_pkg::PATTERN_RESET;
      end
    end else if (wr_i.en) begin
      pat_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = pat_q[rd_addr_i];

endmodule

>>> hw/rtl/fsu_hold_acc.sv
// ----------------------------------------------------------------------------
// fsu_hold_acc
// Shared adder that accumulates the hold time over one word's actuations.
// ----------------------------------------------------------------------------
module fsu_hold_acc (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fsu_pkg::acc_ctrl_t              ctrl_i,
  input  logic [fsu_pkg::CMP_W-1:0]       hold_ms_i,
  output logic [fsu_pkg::ELAPSED_W-1:0]   sum_o
);

  logic [fsu_pkg::ELAPSED_W-1:0] acc_q, acc_d;

  // running total plus one more hold period
  assign sum_o = acc_q + fsu_pkg::ELAPSED_W'(hold_ms_i);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.add) begin
      acc_d = sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

>>> hw/rtl/flip_segment_update_sequencer.sv
// A word is registered on acceptance and its pattern is compared with the stored
// one; then the segment scan issues at most one actuation per cycle, a..g in
// order, and holds while the output stalls. A new word is taken only when the
// scan has ended at the highest changed segment, or straight after the compare
// if nothing changes; a word with an out-of-range digit is taken and dropped.
// Reset (async, active low): all digits read as fully shown, registers reload.
// ----------------------------------------------------------------------------
// flip_segment_update_sequencer
// Decodes a symbol for one digit and sequences the segment flips it needs.
// ----------------------------------------------------------------------------
`include "flip_segment_update_sequencer_assert.svh"

module flip_segment_update_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fsu_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fsu_pkg::CMP_W-1:0]            cfg_data_i,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [fsu_pkg::DIGIT_W-1:0]          digit_index_i,
  input  logic [fsu_pkg::SYMBOL_W-1:0]         symbol_i,
  // actuation words
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [fsu_pkg::PORT_W-1:0]           port_value_o,
  output logic [fsu_pkg::SEG_W-1:0]            segment_number_o,
  output logic                                 drive_on_o,
  output logic [fsu_pkg::CMP_W-1:0]            pwm_compare_o,
  output logic [fsu_pkg::ELAPSED_W-1:0]        elapsed_ms_o,
  output logic                                 last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN
  } state_e;

  localparam logic [fsu_pkg::DIGIT_W-1:0] DigitLimit = fsu_pkg::DIGIT_W'(fsu_pkg::DIGITS);
  localparam logic [fsu_pkg::SEG_W-1:0]   SegLast    = fsu_pkg::SEG_W'(fsu_pkg::SEGMENTS - 1);

  // configuration registers, always ready
  logic [fsu_pkg::CMP_W-1:0] set_cmp_q, clr_cmp_q, hold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_cmp_q <= fsu_pkg::SET_CMP_RESET;
      clr_cmp_q <= fsu_pkg::CLR_CMP_RESET;
      hold_q    <= fsu_pkg::HOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fsu_pkg::CFG_SET_CMP: set_cmp_q <= cfg_data_i;
        fsu_pkg::CFG_CLR_CMP: clr_cmp_q <= cfg_data_i;
        fsu_pkg::CFG_HOLD:    hold_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state and registered outputs
  state_e                          state_q, state_d;
  logic [fsu_pkg::DIGIT_AW-1:0]    digit_q, digit_d;
  logic [fsu_pkg::SEGMENTS-1:0]    next_q, next_d;
  logic [fsu_pkg::SEGMENTS-1:0]    diff_q, diff_d;
  logic [fsu_pkg::SEG_W-1:0]       seg_q, seg_d;
  logic                            out_valid_q, out_valid_d;
  logic [fsu_pkg::PORT_W-1:0]      port_q, port_d;
  logic [fsu_pkg::SEG_W-1:0]       segnum_q, segnum_d;
  logic                            drive_q, drive_d;
  logic [fsu_pkg::CMP_W-1:0]       pwm_q, pwm_d;
  logic [fsu_pkg::ELAPSED_W-1:0]   elapsed_q, elapsed_d;
  logic                            last_q, last_d;

  logic                            in_accept;
  logic                            out_free;
  logic                            out_load;
  logic                            seg_hit;
  logic                            seg_last;
  logic                            seg_on;
  logic [fsu_pkg::SEGMENTS-1:0]    stored_pat;
  logic [fsu_pkg::ELAPSED_W-1:0]   acc_sum;
  logic [fsu_pkg::PORT_W-1:0]      chip_sel;
  fsu_pkg::pat_wr_t                pat_wr;
  fsu_pkg::acc_ctrl_t              acc_ctrl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  fsu_pattern_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (digit_q),
    .rd_data_o (stored_pat),
    .wr_i      (pat_wr)
  );

  fsu_hold_acc u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (acc_ctrl),
    .hold_ms_i (hold_q),
    .sum_o     (acc_sum)
  );

  // current segment of the scan
  assign seg_hit  = diff_q[seg_q];
  assign seg_on   = next_q[seg_q];
  assign seg_last = (((diff_q >> seg_q) >> 1) == '0);
  assign out_load = (state_q == ST_SCAN) && seg_hit && out_free;
  assign chip_sel = fsu_pkg::PORT_W'(1) << (fsu_pkg::CHIP_SEL_BASE + int'(digit_q));

  // new pattern goes to the store once the difference is captured
  assign pat_wr.en   = (state_q == ST_LOAD);
  assign pat_wr.addr = digit_q;
  assign pat_wr.data = next_q;

  assign acc_ctrl.clear = (state_q == ST_LOAD);
  assign acc_ctrl.add   = out_load;

  always_comb begin
    state_d     = state_q;
    digit_d     = digit_q;
    next_d      = next_q;
    diff_d      = diff_q;
    seg_d       = seg_q;
    out_valid_d = out_valid_q && out_stall_i;
    port_d      = port_q;
    segnum_d    = segnum_q;
    drive_d     = drive_q;
    pwm_d       = pwm_q;
    elapsed_d   = elapsed_q;
    last_d      = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (digit_index_i < DigitLimit)) begin
          digit_d = digit_index_i[fsu_pkg::DIGIT_AW-1:0];
          next_d  = fsu_pkg::glyph(symbol_i);
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        diff_d  = next_q ^ stored_pat;
        seg_d   = '0;
        state_d = ((next_q ^ stored_pat) == '0) ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (!seg_hit) begin
          seg_d = seg_q + 1'b1;
          if (seg_q == SegLast) begin
            state_d = ST_IDLE;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          port_d      = chip_sel | (fsu_pkg::PORT_W'(1) << fsu_pkg::PULLUP_BIT)
                      | fsu_pkg::PORT_W'({seg_q[0], seg_q[1], seg_q[2]});
          segnum_d    = seg_q;
          drive_d     = seg_on;
          pwm_d       = seg_on ? set_cmp_q : clr_cmp_q;
          elapsed_d   = acc_sum;
          last_d      = seg_last;
          seg_d       = seg_q + 1'b1;
          if (seg_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      digit_q     <= '0;
      next_q      <= '0;
      diff_q      <= '0;
      seg_q       <= '0;
      out_valid_q <= 1'b0;
      port_q      <= '0;
      segnum_q    <= '0;
      drive_q     <= 1'b0;
      pwm_q       <= '0;
      elapsed_q   <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      digit_q     <= digit_d;
      next_q      <= next_d;
      diff_q      <= diff_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
      port_q      <= port_d;
      segnum_q    <= segnum_d;
      drive_q     <= drive_d;
      pwm_q       <= pwm_d;
      elapsed_q   <= elapsed_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign port_value_o     = port_q;
  assign segment_number_o = segnum_q;
  assign drive_on_o       = drive_q;
  assign pwm_compare_o    = pwm_q;
  assign elapsed_ms_o     = elapsed_q;
  assign last_o           = last_q;

  // checks
  `FSU_ASSERT_NEXT(a_valid_digit_loads, clk_i, rst_ni,
    in_accept && (digit_index_i < DigitLimit), state_q == ST_LOAD,
    "accepted digit did not start a compare")
  `FSU_ASSERT_NEXT(a_last_ends_scan, clk_i, rst_ni,
    out_load && seg_last, state_q == ST_IDLE && out_valid_q && last_q,
    "final actuation did not end the scan")
  `FSU_ASSERT_NOW(a_scan_has_work, clk_i, rst_ni,
    state_q == ST_SCAN, diff_q != '0,
    "scan running with no segment to flip")
  `FSU_ASSERT_NOW(a_scan_seg_range, clk_i, rst_ni,
    state_q == ST_SCAN, seg_q <= SegLast,
    "segment counter out of range")

endmodule

>>> sim/flip_sequence_checker.sv
// ----------------------------------------------------------------------------
// Flip sequence checker
// Watches the configuration, input and actuation channels of the flip segment
// sequencer, keeps its own copy of the digit patterns and registers, predicts
// the actuation words of every accepted input word and compares them in order.
// ----------------------------------------------------------------------------
module flip_sequence_checker
  import fsu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CMP_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [DIGIT_W-1:0]   digit_index_i,
  input  logic [SYMBOL_W-1:0]  symbol_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [PORT_W-1:0]    port_value_i,
  input  logic [SEG_W-1:0]     segment_number_i,
  input  logic                 drive_on_i,
  input  logic [CMP_W-1:0]     pwm_compare_i,
  input  logic [ELAPSED_W-1:0] elapsed_ms_i,
  input  logic                 last_i,
  output int                   pending_o,
  output int                   mismatches_o
);

  localparam int SYMBOLS_KNOWN = 18;

  // segment bits per symbol, symbol 0 in the low seven bits
  localparam logic [SYMBOLS_KNOWN*SEGMENTS-1:0] GLYPH_ROM = {
    7'h40, 7'h00, 7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F,
    7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  typedef struct packed {
    logic [PORT_W-1:0]    port_value;
    logic [SEG_W-1:0]     segment;
    logic                 drive_on;
    logic [CMP_W-1:0]     pwm;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 last;
  } flip_t;

  flip_t               flips_q[$];
  logic [SEGMENTS-1:0] shown_q [DIGITS];
  logic [CMP_W-1:0]    set_cmp_q;
  logic [CMP_W-1:0]    clr_cmp_q;
  logic [CMP_W-1:0]    hold_q;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches_o < 40) begin
      $display("%0t checker: %s got %0h want %0h", $realtime, what, got, want);
    end
    mismatches_o = mismatches_o + 1;
  endtask

  // decode a symbol for a digit and queue one flip per changed segment
  task automatic queue_flips(input logic [DIGIT_W-1:0] digit,
                             input logic [SYMBOL_W-1:0] sym);
    logic [SEGMENTS-1:0]  glyph_bits;
    logic [SEGMENTS-1:0]  changed;
    logic [ELAPSED_W-1:0] held;
    logic [SEG_W-1:0]     seg_num;
    flip_t                f;
    if (int'(digit) >= DIGITS) return;
    glyph_bits = (int'(sym) < SYMBOLS_KNOWN) ? GLYPH_ROM[int'(sym)*SEGMENTS +: SEGMENTS]
                                             : '0;
    changed = glyph_bits ^ shown_q[digit];
    held = '0;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (changed[seg]) begin
        seg_num = SEG_W'(seg);
        held = held + ELAPSED_W'(hold_q);
        f = '0;
        f.port_value[CHIP_SEL_BASE + int'(digit)] = 1'b1;
        f.port_value[PULLUP_BIT] = 1'b1;
        f.port_value[2:0] = {seg_num[0], seg_num[1], seg_num[2]};
        f.segment  = seg_num;
        f.drive_on = glyph_bits[seg];
        f.pwm      = glyph_bits[seg] ? set_cmp_q : clr_cmp_q;
        f.elapsed  = held;
        f.last     = ((changed >> (seg + 1)) == '0);
        flips_q.push_back(f);
      end
    end
    shown_q[digit] = glyph_bits;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    flip_t want;
    if (!rst_ni) begin
      for (int d = 0; d < DIGITS; d++) shown_q[d] = PATTERN_RESET;
      set_cmp_q = SET_CMP_RESET;
      clr_cmp_q = CLR_CMP_RESET;
      hold_q    = HOLD_RESET;
      flips_q.delete();
      mismatches_o = 0;
      pending_o <= 0;
    end else begin
      // compare an accepted actuation word with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (flips_q.size() == 0) begin
          report_mismatch("word with nothing pending, port_value", port_value_i, '0);
        end else begin
          want = flips_q.pop_front();
          if (port_value_i !== want.port_value)
            report_mismatch("port_value", port_value_i, want.port_value);
          if (segment_number_i !== want.segment)
            report_mismatch("segment_number", segment_number_i, want.segment);
          if (drive_on_i !== want.drive_on)
            report_mismatch("drive_on", drive_on_i, want.drive_on);
          if (pwm_compare_i !== want.pwm)
            report_mismatch("pwm_compare", pwm_compare_i, want.pwm);
          if (elapsed_ms_i !== want.elapsed)
            report_mismatch("elapsed_ms", elapsed_ms_i, want.elapsed);
          if (last_i !== want.last)
            report_mismatch("last", last_i, want.last);
        end
      end
      // register writes; unused indexes change nothing
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SET_CMP: set_cmp_q = cfg_data_i;
          CFG_CLR_CMP: clr_cmp_q = cfg_data_i;
          CFG_HOLD:    hold_q    = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) queue_flips(digit_index_i, symbol_i);
      pending_o <= flips_q.size();
    end
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Flip segment sequencer testbench
// Drives directed and random digit updates through several register settings,
// with bursty input and a varying output stall; the checker beside the block
// predicts and compares every actuation word.
// ----------------------------------------------------------------------------
module testbench;
  import fsu_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // receiver stall modes
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CMP_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DIGIT_W-1:0]   digit_index = '0;
  logic [SYMBOL_W-1:0]  symbol = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PORT_W-1:0]    port_value;
  logic [SEG_W-1:0]     segment_number;
  logic                 drive_on;
  logic [CMP_W-1:0]     pwm_compare;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic                 last;
  int                   pending;
  int                   mismatches;

  int cycle_count = 0;
  int burst_left = 0;
  bit sending = 1'b0;
  int stall_left = 0;
  int stall_mode = STALL_NONE;

  always #4 clk = ~clk;

  flip_segment_update_sequencer u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .digit_index_i    (digit_index),
    .symbol_i         (symbol),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .port_value_o     (port_value),
    .segment_number_o (segment_number),
    .drive_on_o       (drive_on),
    .pwm_compare_o    (pwm_compare),
    .elapsed_ms_o     (elapsed_ms),
    .last_o           (last)
  );

  flip_sequence_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .digit_index_i    (digit_index),
    .symbol_i         (symbol),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .port_value_i     (port_value),
    .segment_number_i (segment_number),
    .drive_on_i       (drive_on),
    .pwm_compare_i    (pwm_compare),
    .elapsed_ms_i     (elapsed_ms),
    .last_i           (last),
    .pending_o        (pending),
    .mismatches_o     (mismatches)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall: modes of random length, one of them never stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(STALL_HEAVY);
      stall_left <= $urandom_range(60, 8);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
      default:     out_stall <= ($urandom_range(1) == 1);
    endcase
  end

  // one input word; valid stays high within a burst, a gap follows each burst
  task automatic send_word(input logic [DIGIT_W-1:0] d, input logic [SYMBOL_W-1:0] s);
    int gap;
    in_valid    <= 1'b1;
    digit_index <= d;
    symbol      <= s;
    sending = 1'b1;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      sending = 1'b0;
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 15) : $urandom_range(10);
    end
  endtask

  // random words; rejected digits are sent too but not counted
  task automatic send_random(input int count);
    logic [DIGIT_W-1:0]  d;
    logic [SYMBOL_W-1:0] s;
    int                  taken;
    taken = 0;
    while (taken < count) begin
      d = ($urandom_range(99) < 88) ? DIGIT_W'($urandom_range(DIGITS - 1))
                                    : DIGIT_W'($urandom_range(7, DIGITS));
      s = ($urandom_range(99) < 85) ? SYMBOL_W'($urandom_range(17))
                                    : SYMBOL_W'($urandom_range(31, 18));
      send_word(d, s);
      if (int'(d) < DIGITS) taken++;
    end
  endtask

  // wait until every predicted flip has come out and the block is idle
  task automatic settle();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the three registers back to back
  task automatic write_regs(input logic [CMP_W-1:0] set_val, input logic [CMP_W-1:0] clr_val,
                            input logic [CMP_W-1:0] hold_val);
    logic [CMP_W-1:0]     vals [3];
    logic [CFG_IDX_W-1:0] idxs [3];
    vals = '{set_val, clr_val, hold_val};
    idxs = '{CFG_SET_CMP, CFG_CLR_CMP, CFG_HOLD};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic write_spare(input logic [CMP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset register values; all digits start fully shown
    send_word(3'd0, 5'd8);   // nothing to change
    send_word(3'd0, 5'd16);  // blank: every segment hidden
    send_word(3'd0, 5'd8);   // every segment shown again
    send_word(3'd4, 5'd0);   // digit out of range
    send_word(3'd7, 5'd31);  // digit out of range, all bits high
    send_word(3'd1, 5'd0);
    send_word(3'd1, 5'd1);
    send_word(3'd2, 5'd17);  // minus sign
    send_word(3'd2, 5'd31);  // unknown symbol reads as blank
    send_word(3'd2, 5'd18);  // unknown again, already blank
    send_word(3'd3, 5'd15);
    send_word(3'd3, 5'd10);
    send_word(3'd3, 5'd0);
    send_word(3'd1, 5'd8);
    send_random(15);
    settle();

    write_regs(16'd0, 16'hFFFF, 16'hFFFF);
    send_random(35);
    settle();

    write_regs(16'hFFFF, 16'd0, 16'd0);
    write_spare(16'hFFFF);
    send_random(30);
    settle();

    write_regs(CMP_W'($urandom), CMP_W'($urandom), CMP_W'($urandom));
    send_random(35);
    settle();

    write_regs(CMP_W'($urandom), CMP_W'($urandom), CMP_W'($urandom_range(9, 1)));
    write_spare(16'd0);
    send_random(25);
    settle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
